// ===== hdl/tswm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// types and codes shared by the three-way sorted merge
// controller, datapath and top level; no dependencies

package tswm_pkg;

  localparam int unsigned ValueW = 32;

  // request kinds carried in tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // list selector codes
  localparam logic [1:0] LIST_A = 2'd0;
  localparam logic [1:0] LIST_B = 2'd1;
  localparam logic [1:0] LIST_C = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;        // store the incoming element
    logic start;       // latch merge setup from the start transaction
    logic step;        // pop the smallest head into the output register
    logic empty_emit;  // emit the empty-merge result
  } tswm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic total_zero;  // every taking-part list is empty (start transaction)
    logic out_free;    // output register can take a result this cycle
    logic last_pick;   // the current pick is the final element
  } tswm_status_t;

endpackage

`default_nettype wire

// ===== hdl/three_way_sorted_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Three-way sorted merge. A load transaction (tuser req_type 0) stores one element into list
// A, B or C; a load into a full list is dropped and flagged, list code 3 is ignored.
// A start transaction (req_type 1) merges lists A and B, plus C when use_third is set, and emits
// every element smallest first with tlast on the final one, one element per cycle from a
// two-level compare of the three list heads into the output register, stalled while that
// register holds a result and out_tready is low. With every list empty a single result with
// empty_merge set is loaded into the output register from the empty state. The input is
// not ready while a merge runs. All lists and the drop flag are cleared by each merge.
// depends on tswm_pkg, tswm_ctrl and tswm_dp

module three_way_sorted_merge
  import tswm_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 16
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // elem_value[31:0], use_third[32], zero[39:33]
  input  wire logic [2:0]  in_tuser,   // req_type[0], list_sel[2:1]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // merged_value[31:0]
  output logic             out_tlast,
  output logic [1:0]       out_tuser   // empty_merge[0], overflowed[1]
);

  tswm_cmd_t    cmd;
  tswm_status_t status;
  logic         empty_merge;
  logic         overflowed;

  tswm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .req_type  (in_tuser[0]),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tswm_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .list_sel     (in_tuser[2:1]),
    .elem_value   (in_tdata[31:0]),
    .use_third    (in_tdata[32]),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .merged_value (out_tdata),
    .last_out     (out_tlast),
    .empty_merge  (empty_merge),
    .overflowed   (overflowed)
  );

  assign out_tuser = {overflowed, empty_merge};

endmodule

`default_nettype wire

// ===== hdl/tswm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// merge controller: idle / merge / empty-result sequencing
// depends on tswm_pkg for the command and status structs

module tswm_ctrl
  import tswm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         req_type,
  output logic              in_tready,
  input  tswm_status_t      status,
  output tswm_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_EMPTY
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    cmd.load       = 1'b0;
    cmd.start      = 1'b0;
    cmd.step       = 1'b0;
    cmd.empty_emit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_START) begin
            cmd.start = 1'b1;
            state_nxt = status.total_zero ? ST_EMPTY : ST_MERGE;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_MERGE: begin
        cmd.step = status.out_free;
        if (status.out_free && status.last_pick) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        cmd.empty_emit = status.out_free;
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tswm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// merge datapath: three list buffers, fill counts, read pointers,
// head compare and output register; depends on tswm_pkg

module tswm_dp
  import tswm_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 16
)(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  tswm_cmd_t               cmd,
  output tswm_status_t            status,
  input  wire logic [1:0]         list_sel,
  input  wire logic [ValueW-1:0]  elem_value,
  input  wire logic               use_third,
  input  wire logic               out_tready,
  output logic                    out_tvalid,
  output logic [ValueW-1:0]       merged_value,
  output logic                    last_out,
  output logic                    empty_merge,
  output logic                    overflowed
);

  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IdxW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned RemW = $clog2(3 * LIST_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(LIST_DEPTH);

  logic [ValueW-1:0] store_a [LIST_DEPTH];
  logic [ValueW-1:0] store_b [LIST_DEPTH];
  logic [ValueW-1:0] store_c [LIST_DEPTH];

  logic [CntW-1:0] cnt_a_r, cnt_b_r, cnt_c_r;
  logic [CntW-1:0] ptr_a_r, ptr_b_r, ptr_c_r;
  logic [RemW-1:0] rem_r;
  logic            drop_r;
  logic            third_r;
  logic            out_valid_r;

  logic [RemW-1:0]   total_nxt;
  logic              a_ok, b_ok, c_ok, ab_ok, pick_b, pick_c;
  logic [ValueW-1:0] head_a, head_b, head_c, best_ab, best;
  logic              finish;

  assign total_nxt = RemW'(cnt_a_r) + RemW'(cnt_b_r) + (use_third ? RemW'(cnt_c_r) : '0);

  assign head_a = store_a[ptr_a_r[IdxW-1:0]];
  assign head_b = store_b[ptr_b_r[IdxW-1:0]];
  assign head_c = store_c[ptr_c_r[IdxW-1:0]];

  assign a_ok = ptr_a_r < cnt_a_r;
  assign b_ok = ptr_b_r < cnt_b_r;
  assign c_ok = third_r && (ptr_c_r < cnt_c_r);

  // a against b, then the winner against c
  assign pick_b  = b_ok && (!a_ok || (head_b < head_a));
  assign best_ab = pick_b ? head_b : head_a;
  assign ab_ok   = a_ok || b_ok;
  assign pick_c  = c_ok && (!ab_ok || (head_c < best_ab));
  assign best    = pick_c ? head_c : best_ab;

  assign status.total_zero = (total_nxt == '0);
  assign status.out_free   = !out_valid_r || out_tready;
  assign status.last_pick  = (rem_r == RemW'(1));

  assign finish = (cmd.step && status.last_pick) || cmd.empty_emit;

  // buffers hold no reset, entries are only read below their count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      unique case (list_sel)
        LIST_A:  if (cnt_a_r < DepthC) store_a[cnt_a_r[IdxW-1:0]] <= elem_value;
        LIST_B:  if (cnt_b_r < DepthC) store_b[cnt_b_r[IdxW-1:0]] <= elem_value;
        LIST_C:  if (cnt_c_r < DepthC) store_c[cnt_c_r[IdxW-1:0]] <= elem_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      cnt_c_r <= '0;
      drop_r  <= 1'b0;
    end else if (finish) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      cnt_c_r <= '0;
      drop_r  <= 1'b0;
    end else if (cmd.load) begin
      unique case (list_sel)
        LIST_A: begin
          if (cnt_a_r < DepthC) cnt_a_r <= cnt_a_r + CntW'(1);
          else drop_r <= 1'b1;
        end
        LIST_B: begin
          if (cnt_b_r < DepthC) cnt_b_r <= cnt_b_r + CntW'(1);
          else drop_r <= 1'b1;
        end
        LIST_C: begin
          if (cnt_c_r < DepthC) cnt_c_r <= cnt_c_r + CntW'(1);
          else drop_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_a_r <= '0;
      ptr_b_r <= '0;
      ptr_c_r <= '0;
      rem_r   <= '0;
      third_r <= 1'b0;
    end else if (cmd.start) begin
      ptr_a_r <= '0;
      ptr_b_r <= '0;
      ptr_c_r <= '0;
      rem_r   <= total_nxt;
      third_r <= use_third;
    end else if (cmd.step) begin
      rem_r <= rem_r - RemW'(1);
      if (pick_c)      ptr_c_r <= ptr_c_r + CntW'(1);
      else if (pick_b) ptr_b_r <= ptr_b_r + CntW'(1);
      else             ptr_a_r <= ptr_a_r + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step || cmd.empty_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      merged_value <= best;
      last_out     <= status.last_pick;
      empty_merge  <= 1'b0;
      overflowed   <= drop_r;
    end else if (cmd.empty_emit) begin
      merged_value <= '0;
      last_out     <= 1'b1;
      empty_merge  <= 1'b1;
      overflowed   <= drop_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire
